/* rtl/wqfp_pkg.sv */
// Package for the waiter queue: item and result beat types, mode and status
// codes, and default sizes. No dependencies.
package wqfp_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_WAITERS_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;

    // Operation codes carried in the item mode field
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_WAKE   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

    // One input beat
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] task_id;
        logic [7:0] priority_req;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] woken_id;
        logic [4:0] waiting_count;
    } result_t;

endpackage

/* rtl/waiter_queue_fifo_or_priority.sv */
// Waiter queue top level: arrival-ordered list of task ids with priorities,
// held in one synchronous entry memory. Depends on wqfp_pkg.
//
// Usage:
//   item channel (item_valid / item_stall / item) carries add, delete and wake
//   commands; result channel (result_valid / result_stall / result) returns
//   exactly one beat per item. cfg channel (cfg_valid / cfg_ready / cfg_data)
//   writes the discipline bit: 0 serves the oldest waiter, 1 the earliest
//   waiter of strictly highest priority. Write it only while the block idles.
// Sequencing, with N waiters in the list:
//   add and unused mode go straight to the result register.
//   delete: scan entries from the head up to the match at entry k, then
//   shift the entries above k down; no match scans all N. Wake: FIFO reads
//   the head only, priority scans all N, then the entries above the pick shift.
//   The single read port of the entry memory sets the pace: the scan reads
//   one entry a cycle, and closing the gap moves one entry a cycle (read
//   ahead, write one slot lower).
//   One item is worked at a time; item_stall is high while an item is busy.
// Reset empties the list and clears the discipline to FIFO; the memory needs
//   no clearing pass. A finished result waits in the output register while the
//   next item is accepted; a held result blocks only the completion of the
//   following item.
module waiter_queue_fifo_or_priority #(
    parameter int MAX_WAITERS   = wqfp_pkg::MAX_WAITERS_DEF,
    parameter int PRIORITY_BITS = wqfp_pkg::PRIORITY_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  wqfp_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_stall,
    output wqfp_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);
    import wqfp_pkg::*;

    localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WAITERS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    typedef struct packed {
        logic [7:0]               id;
        logic [PRIORITY_BITS-1:0] prio;
    } entry_t;

    // Entry memory and its registered read port
    entry_t mem [0:MAX_WAITERS-1];
    entry_t rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    // Control and working registers
    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic                     disc_reg;
    logic [1:0]               mode_reg, mode_next;
    logic [7:0]               id_reg, id_next;
    logic [CNT_W-1:0]         chk_reg, chk_next;
    logic [CNT_W-1:0]         pos_reg, pos_next;
    logic [PRIORITY_BITS-1:0] best_prio_reg, best_prio_next;
    logic [7:0]               best_id_reg, best_id_next;
    logic [CNT_W-1:0]         src_reg, src_next;
    logic [IDX_W-1:0]         dst_reg, dst_next;
    logic                     dv_reg, dv_next;
    logic [1:0]               res_status_reg, res_status_next;
    logic [7:0]               res_woken_reg, res_woken_next;
    logic                     result_valid_reg;
    result_t                  result_reg;

    logic [CNT_W-1:0] chk_inc;
    logic [CNT_W-1:0] src_dec;
    logic [CNT_W-1:0] sel_pos;
    logic             chk_last;
    logic             take;
    logic             accept;
    logic             out_load;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign chk_inc    = chk_reg + 1'b1;
    assign src_dec    = src_reg - 1'b1;
    assign chk_last   = (chk_inc == occ_reg);
    assign take       = !disc_reg || (chk_reg == '0) || (rd_data_reg.prio > best_prio_reg);
    assign sel_pos    = take ? chk_reg : pos_reg;
    assign out_load   = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);

    // Sequence one item: immediate ops, scan, gap close, result hand-off
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        chk_next        = chk_reg;
        pos_next        = pos_reg;
        best_prio_next  = best_prio_reg;
        best_id_next    = best_id_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        dv_next         = dv_reg;
        res_status_next = res_status_reg;
        res_woken_next  = res_woken_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = occ_reg[IDX_W-1:0];
        wr_data         = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next       = item.mode;
                    id_next         = item.task_id;
                    res_status_next = STATUS_OK;
                    res_woken_next  = '0;
                    chk_next        = '0;
                    state_next      = S_DONE;
                    case (item.mode)
                        MODE_ADD:
                        begin
                            if (occ_reg >= MAX_CNT)
                                res_status_next = STATUS_FULL;
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = occ_reg[IDX_W-1:0];
                                wr_data.id   = item.task_id;
                                wr_data.prio = PRIORITY_BITS'(item.priority_req);
                                occ_next     = occ_reg + 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (occ_reg == '0)
                                res_status_next = STATUS_NOT_FOUND;
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        MODE_WAKE:
                        begin
                            if (occ_reg == '0)
                                res_status_next = STATUS_EMPTY;
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN:
            begin
                if (mode_reg == MODE_DELETE)
                begin
                    if (rd_data_reg.id == id_reg)
                    begin
                        pos_next   = chk_reg;
                        src_next   = chk_inc;
                        dv_next    = 1'b0;
                        state_next = S_SHIFT;
                    end
                    else if (chk_last)
                    begin
                        res_status_next = STATUS_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = chk_inc[IDX_W-1:0];
                        chk_next = chk_inc;
                    end
                end
                else
                begin
                    // Track the earliest strictly-highest priority entry
                    if (take)
                    begin
                        best_prio_next = rd_data_reg.prio;
                        best_id_next   = rd_data_reg.id;
                        pos_next       = chk_reg;
                    end
                    if (!disc_reg || chk_last)
                    begin
                        res_woken_next = take ? rd_data_reg.id : best_id_reg;
                        src_next       = sel_pos + 1'b1;
                        dv_next        = 1'b0;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = chk_inc[IDX_W-1:0];
                        chk_next = chk_inc;
                    end
                end
            end

            S_SHIFT:
            begin
                // Write the entry read last cycle one slot lower
                if (dv_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data_reg;
                end
                if (src_reg < occ_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = src_reg[IDX_W-1:0];
                    src_next = src_reg + 1'b1;
                    dst_next = src_dec[IDX_W-1:0];
                    dv_next  = 1'b1;
                end
                else
                begin
                    dv_next    = 1'b0;
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Entry memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            occ_reg          <= '0;
            disc_reg         <= 1'b0;
            dv_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            dv_reg    <= dv_next;
            if (cfg_valid && cfg_ready)
                disc_reg <= cfg_data;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        chk_reg        <= chk_next;
        pos_reg        <= pos_next;
        best_prio_reg  <= best_prio_next;
        best_id_reg    <= best_id_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        res_status_reg <= res_status_next;
        res_woken_reg  <= res_woken_next;
        if (out_load)
        begin
            result_reg.status        <= res_status_reg;
            result_reg.woken_id      <= res_woken_reg;
            result_reg.waiting_count <= 5'(occ_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Occupancy never exceeds the list size
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= MAX_CNT)
        else $error("waiter count above list size");

    // Occupancy moves by at most one per cycle
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == $past(occ_reg)) || (occ_reg == $past(occ_reg) + 1'b1)
        || (occ_reg + 1'b1 == $past(occ_reg)))
        else $error("waiter count jumped");

    // Memory writes only on an add or while closing a gap
    a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_IDLE) || (state_reg == S_SHIFT)))
        else $error("entry write outside add or shift");

    // An empty-list result names no task and reports no waiters
    a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == STATUS_EMPTY))
        |-> ((result.woken_id == 8'd0) && (result.waiting_count == 5'd0)))
        else $error("empty result carries data");

    // A full result reports a full list
    a_full_res: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == STATUS_FULL))
        |-> (result.waiting_count == 5'(MAX_WAITERS)))
        else $error("full result with spare room");

endmodule
